>>> hw/rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

  // Field and bus widths of the two streams, and the default list depth.
  localparam int CMD_W       = 3;
  localparam int POS_W       = 6;
  localparam int VAL_W       = 8;
  localparam int CNT_OUT_W   = 6;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 24;
  localparam int DEPTH_DEFAULT = 32;

  // Command codes carried in the cmd field.
  typedef enum logic [CMD_W-1:0] {
    OP_GET    = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GETDATA,
    S_DELHEAD,
    S_WALK,
    S_DRAIN,
    S_PUTVAL,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted item
    logic rd_pos;      // read the entry at position - 1
    logic take_entry;  // keep the read data as the result entry
    logic walk_start;  // set up the walk pointer and end for the current command
    logic walk_read;   // read at the walk pointer and advance it
    logic walk_proc;   // act on the data read in the previous walk cycle
    logic put_val;     // write the item value at position - 1
    logic set_err;     // mark the result as an error
    logic out_load;    // load the output register and commit the count
  } ple_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic rd_ok;       // position within 1..count
    logic ins_ok;      // insert position within 1..count+1 and room left
    logic ins_tail;    // insert lands right after the last entry
    logic del_tail;    // delete takes the last entry
    logic empty;       // count is zero
    logic walk_last;   // walk pointer sits on its final entry
    logic match;       // previous walk read equals the search value
    logic out_free;    // output register can take a result this cycle
  } ple_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ple_datapath.sv
// Datapath of the positional list engine: entry memory, count, walk pointers, output register.
`default_nettype none

module ple_datapath #(
  parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [ple_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [ple_pkg::M_TDATA_W-1:0]       m_tdata,
  input  wire ple_pkg::ple_cmd_t              cmd,
  output ple_pkg::ple_stat_t                  stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  // Captured item.
  ple_pkg::op_t                op_q;
  logic [ple_pkg::POS_W-1:0]   pos_q;
  logic [ple_pkg::VAL_W-1:0]   val_q;

  // List state.
  logic [ple_pkg::VAL_W-1:0]   mem [DEPTH];
  logic [ple_pkg::VAL_W-1:0]   rdata;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;

  // Walk state.
  logic [AW-1:0]               ptr;
  logic [AW-1:0]               end_idx;
  logic                        dir_down;
  logic [AW-1:0]               prev_addr;
  logic                        prev_vld;

  // Result under construction.
  logic                        err_q;
  logic [ple_pkg::VAL_W-1:0]   entry_q;
  logic [ple_pkg::CNT_OUT_W-1:0] found_q;

  // Output register fields.
  logic                        out_status;
  logic [ple_pkg::VAL_W-1:0]   out_entry;
  logic [ple_pkg::CNT_OUT_W-1:0] out_found;
  logic [ple_pkg::CNT_OUT_W-1:0] out_count;

  // Derived positions and indexes.
  logic [PW-1:0]               pos_ext;
  logic [PW-1:0]               cnt_ext;
  logic [PW-1:0]               pos_m1_ext;
  logic [PW-1:0]               cnt_m1_ext;
  logic [PW-1:0]               found_ext;
  logic [PW-1:0]               cnt_next_ext;
  logic [AW-1:0]               pos_m1;
  logic [AW-1:0]               cnt_m1;
  logic [AW-1:0]               pos_idx;

  // Memory port controls.
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [ple_pkg::VAL_W-1:0]   wr_data;
  logic                        is_shift_op;

  assign pos_ext    = PW'(pos_q);
  assign cnt_ext    = PW'(count);
  assign pos_m1_ext = pos_ext - PW'(1);
  assign cnt_m1_ext = cnt_ext - PW'(1);
  assign pos_m1     = pos_m1_ext[AW-1:0];
  assign cnt_m1     = cnt_m1_ext[AW-1:0];
  assign pos_idx    = pos_ext[AW-1:0];
  assign found_ext  = PW'(prev_addr) + PW'(1);

  // Status toward the controller.
  always_comb begin
    stat.op        = op_q;
    stat.rd_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
    stat.ins_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1))
                     && (cnt_ext < PW'(DEPTH));
    stat.ins_tail  = (pos_ext == cnt_ext + PW'(1));
    stat.del_tail  = (pos_ext == cnt_ext);
    stat.empty     = (count == '0);
    stat.walk_last = (ptr == end_idx);
    stat.match     = prev_vld && (rdata == val_q);
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= ple_pkg::op_t'(s_tdata[ple_pkg::CMD_W-1:0]);
      pos_q <= s_tdata[ple_pkg::CMD_W +: ple_pkg::POS_W];
      val_q <= s_tdata[ple_pkg::CMD_W + ple_pkg::POS_W +: ple_pkg::VAL_W];
    end
  end

  // Memory port selection. A walk write uses the data of the previous walk read.
  assign is_shift_op = (op_q == ple_pkg::OP_INSERT) || (op_q == ple_pkg::OP_DELETE);

  always_comb begin
    rd_en   = cmd.rd_pos || cmd.walk_read;
    rd_addr = cmd.walk_read ? ptr : pos_m1;
    wr_en   = cmd.put_val || (cmd.walk_proc && prev_vld && is_shift_op);
    wr_data = cmd.put_val ? val_q : rdata;
    if (cmd.put_val) begin
      wr_addr = pos_m1;
    end else if (op_q == ple_pkg::OP_INSERT) begin
      wr_addr = prev_addr + AW'(1);
    end else begin
      wr_addr = prev_addr - AW'(1);
    end
  end

  // Entry memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Walk pointer: locate and delete run upward, insert runs downward.
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      unique case (op_q)
        ple_pkg::OP_INSERT: begin
          ptr      <= cnt_m1;
          end_idx  <= pos_m1;
          dir_down <= 1'b1;
        end
        ple_pkg::OP_DELETE: begin
          ptr      <= pos_idx;
          end_idx  <= cnt_m1;
          dir_down <= 1'b0;
        end
        default: begin
          ptr      <= '0;
          end_idx  <= cnt_m1;
          dir_down <= 1'b0;
        end
      endcase
    end else if (cmd.walk_read) begin
      ptr <= dir_down ? ptr - AW'(1) : ptr + AW'(1);
    end
    if (cmd.walk_read) begin
      prev_addr <= ptr;
    end
  end

  // Marks that rdata holds a walk read awaiting its write or compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vld <= 1'b0;
    end else begin
      prev_vld <= cmd.walk_read;
    end
  end

  // Result fields gathered while the command runs.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_q   <= 1'b0;
      entry_q <= '0;
      found_q <= '0;
    end else begin
      if (cmd.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd.take_entry) begin
        entry_q <= rdata;
      end
      if (cmd.walk_proc && (op_q == ple_pkg::OP_LOCATE) && stat.match) begin
        found_q <= found_ext[ple_pkg::CNT_OUT_W-1:0];
      end
    end
  end

  // Count after the command; it changes only on a successful edit or a clear.
  always_comb begin
    count_next = count;
    if (!err_q) begin
      unique case (op_q)
        ple_pkg::OP_INSERT: count_next = count + CW'(1);
        ple_pkg::OP_DELETE: count_next = count - CW'(1);
        ple_pkg::OP_CLEAR:  count_next = '0;
        default:            count_next = count;
      endcase
    end
  end

  assign cnt_next_ext = PW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.out_load) begin
      count <= count_next;
    end
  end

  // Output register; it holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= err_q;
      out_entry  <= entry_q;
      out_found  <= found_q;
      out_count  <= cnt_next_ext[ple_pkg::CNT_OUT_W-1:0];
    end
  end

  assign m_tdata = {3'b000, out_count, out_found, out_entry, out_status};

endmodule

`default_nettype wire

>>> hw/rtl/ple_ctrl.sv
// Controller state machine of the positional list engine.
`default_nettype none

module ple_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire ple_pkg::ple_stat_t stat,
  output ple_pkg::ple_cmd_t       cmd
);

  ple_pkg::state_t state;
  ple_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ple_pkg::S_IDLE: begin
        if (s_tvalid) state_next = ple_pkg::S_DECODE;
      end
      ple_pkg::S_DECODE: begin
        unique case (stat.op)
          ple_pkg::OP_GET:    state_next = stat.rd_ok ? ple_pkg::S_GETDATA : ple_pkg::S_DONE;
          ple_pkg::OP_DELETE: state_next = stat.rd_ok ? ple_pkg::S_DELHEAD : ple_pkg::S_DONE;
          ple_pkg::OP_LOCATE: state_next = stat.empty ? ple_pkg::S_DONE : ple_pkg::S_WALK;
          ple_pkg::OP_INSERT: begin
            state_next = (stat.ins_ok && !stat.ins_tail) ? ple_pkg::S_WALK : ple_pkg::S_DONE;
          end
          default:            state_next = ple_pkg::S_DONE;
        endcase
      end
      ple_pkg::S_GETDATA: state_next = ple_pkg::S_DONE;
      ple_pkg::S_DELHEAD: begin
        state_next = stat.del_tail ? ple_pkg::S_DONE : ple_pkg::S_WALK;
      end
      ple_pkg::S_WALK: begin
        priority if ((stat.op == ple_pkg::OP_LOCATE) && stat.match) begin
          state_next = ple_pkg::S_DONE;
        end else if (stat.walk_last) begin
          state_next = ple_pkg::S_DRAIN;
        end
      end
      ple_pkg::S_DRAIN: begin
        state_next = (stat.op == ple_pkg::OP_INSERT) ? ple_pkg::S_PUTVAL : ple_pkg::S_DONE;
      end
      ple_pkg::S_PUTVAL: state_next = ple_pkg::S_DONE;
      ple_pkg::S_DONE: begin
        if (stat.out_free) state_next = ple_pkg::S_IDLE;
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

  // Outputs toward the datapath and the input stream.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ple_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ple_pkg::S_DECODE: begin
        unique case (stat.op)
          ple_pkg::OP_GET, ple_pkg::OP_DELETE: begin
            cmd.rd_pos  = stat.rd_ok;
            cmd.set_err = !stat.rd_ok;
          end
          ple_pkg::OP_LOCATE: begin
            cmd.walk_start = !stat.empty;
          end
          ple_pkg::OP_INSERT: begin
            cmd.set_err    = !stat.ins_ok;
            cmd.put_val    = stat.ins_ok && stat.ins_tail;
            cmd.walk_start = stat.ins_ok && !stat.ins_tail;
          end
          ple_pkg::OP_CLEAR: begin
            cmd.set_err = 1'b0;
          end
          default: begin
            cmd.set_err = 1'b1;
          end
        endcase
      end
      ple_pkg::S_GETDATA: begin
        cmd.take_entry = 1'b1;
      end
      ple_pkg::S_DELHEAD: begin
        cmd.take_entry = 1'b1;
        cmd.walk_start = !stat.del_tail;
      end
      ple_pkg::S_WALK: begin
        cmd.walk_read = 1'b1;
        cmd.walk_proc = 1'b1;
      end
      ple_pkg::S_DRAIN: begin
        cmd.walk_proc = 1'b1;
      end
      ple_pkg::S_PUTVAL: begin
        cmd.put_val = 1'b1;
      end
      ple_pkg::S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: controller plus datapath.
//
//  Channel  Dir  Accepted when            tdata fields, low bit first
//  s_*      in   s_tvalid && s_tready     cmd[2:0], position[8:3], value[16:9], zero fill
//  m_*      out  m_tvalid && m_tready     status[0], entry_out[8:1], found_at[14:9],
//                                         count_out[20:15], zero fill
//
// One item is worked at a time. Locate, insert and delete walk the entries one per cycle;
// insert and delete also write each entry read back one place over, trailing the reads.
// Reset clears the count and the result valid flag; the entry memory needs no clearing.
// A stalled result sits in the output register; a new item is taken as soon as the
// previous one has been loaded there.
`default_nettype none

module positional_list_engine #(
  parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ple_pkg::S_TDATA_W-1:0] s_tdata,  // cmd, position, value
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ple_pkg::M_TDATA_W-1:0]      m_tdata   // status, entry_out, found_at, count_out
);

  ple_pkg::ple_cmd_t  cmd;
  ple_pkg::ple_stat_t stat;

  // Sequencer.
  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path.
  ple_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

>>> hw/rtl/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
`default_nettype none

module ple_checker #(
  parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [ple_pkg::M_TDATA_W-1:0] m_tdata
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("ple: stalled result changed");

  // Only one item is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ple: item accepted while another is in work");

  // An error result carries no entry and no found position.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[14:1] == 14'd0))
    else $error("ple: error result with payload");

  // The reported count never exceeds the list depth; checked only for DEPTH up to 63.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DEPTH > 63) || (int'(m_tdata[20:15]) <= DEPTH))
    else $error("ple: count beyond depth");

  // No result is offered right after reset.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("ple: result valid after reset");

endmodule

bind positional_list_engine ple_checker #(
  .DEPTH (DEPTH)
) u_ple_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
